>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/spdg_pkg.sv
package spdg_pkg;

  localparam int NODE_FIELD_W   = 6;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int DIST_W         = 22;
  localparam int COUNT_W        = 7;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 7;

  localparam int DEFAULT_MAX_NODES   = 64;
  localparam int DEFAULT_WEIGHT_BITS = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_NODE = 1'd1;

  localparam logic [COUNT_W-1:0]      NODE_COUNT_RESET  = 7'd1;
  localparam logic [NODE_FIELD_W-1:0] SOURCE_NODE_RESET = 6'd0;

  typedef struct packed {
    logic                      operation;
    logic [NODE_FIELD_W-1:0]   from_node;
    logic [NODE_FIELD_W-1:0]   to_node;
    logic [WEIGHT_FIELD_W-1:0] edge_weight;
    logic [NODE_FIELD_W-1:0]   target_node;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              target_invalid;
  } result_t;

endpackage

>>> hdl/shortest_path_dense_graph.sv
// Single-source shortest paths over a dense directed graph.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. A load transaction (operation 0) writes one edge weight into
// the weight memory in that cycle and leaves busy low, so while no query is
// running loads stream at one per cycle. A query transaction (operation 1)
// raises busy and searches the first min(node_count, MAX_NODES) nodes from source_node.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall and must take it then.
// Query sequence: ST_INIT, then ST_RELAX, then ST_FETCH and ST_OUT, which
// raises done; when the source is outside the active nodes, ST_INIT goes
// straight to ST_FETCH. Each settled node costs one ST_RELAX pass over its
// weight row, one weight-memory and one distance-memory read a cycle,
// with the next minimum found during the same pass.
// Configuration: cfg_write with cfg_index and cfg_data writes node_count or
// source_node; the user must write only while busy is low, as the block does not enforce it.
// Reset clears the sequencer and the search flags and sets node_count to 1
// and source_node to 0; the weight memory is not cleared.
module shortest_path_dense_graph
  import spdg_pkg::*;
#(
  parameter int MAX_NODES   = DEFAULT_MAX_NODES,
  parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cmd_t                   cmd,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int WADDR_W = 2 * NODE_W;
  localparam int WDEPTH  = 1 << WADDR_W;
  localparam int SUM_W   = (DIST_W > WEIGHT_BITS ? DIST_W : WEIGHT_BITS) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_RELAX = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state;
  logic [COUNT_W-1:0]      node_count;
  logic [NODE_FIELD_W-1:0] source_node;
  logic [CNT_W-1:0]        n_eff;
  logic [NODE_FIELD_W-1:0] target;
  logic                    target_bad;
  logic                    src_active;
  logic [MAX_NODES-1:0]    reached;
  logic [MAX_NODES-1:0]    settled;
  logic [CNT_W-1:0]        idx;
  logic                    p_vld;
  logic [NODE_W-1:0]       p_idx;
  logic [NODE_W-1:0]       cur_node;
  logic [DIST_W-1:0]       cur_dist;
  logic                    found;
  logic [NODE_W-1:0]       best_node;
  logic [DIST_W-1:0]       best_dist;

  logic                    accept;
  logic [CNT_W-1:0]        n_calc;
  logic                    src_ok;
  logic                    tgt_out;

  logic                    w_we;
  logic [WADDR_W-1:0]      w_waddr;
  logic [WEIGHT_BITS-1:0]  w_wdata;
  logic [WADDR_W-1:0]      w_raddr;
  logic [WEIGHT_BITS-1:0]  w_rd;

  logic                    d_we;
  logic                    d_re;
  logic [NODE_W-1:0]       d_waddr;
  logic [DIST_W-1:0]       d_wdata;
  logic [NODE_W-1:0]       d_raddr;
  logic [DIST_W-1:0]       d_rd;

  logic [SUM_W-1:0]        sum;
  logic [DIST_W-1:0]       nd;
  logic                    eligible;
  logic                    upd;
  logic [DIST_W-1:0]       nv;
  logic                    better;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign n_calc  = (32'(node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                       : CNT_W'(node_count);
  assign src_ok  = 32'(source_node) < 32'(n_calc);
  assign tgt_out = 32'(cmd.target_node) >= 32'(n_calc);

  assign w_we    = accept && (cmd.operation == OP_LOAD)
                   && (32'(cmd.from_node) < 32'(MAX_NODES))
                   && (32'(cmd.to_node) < 32'(MAX_NODES));
  assign w_waddr = {NODE_W'(cmd.from_node), NODE_W'(cmd.to_node)};
  assign w_wdata = WEIGHT_BITS'(cmd.edge_weight);
  assign w_raddr = {cur_node, idx[NODE_W-1:0]};

  spdg_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(WDEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(w_wdata),
    .raddr(w_raddr),
    .rdata(w_rd)
  );

  assign sum      = SUM_W'(cur_dist) + SUM_W'(w_rd);
  assign nd       = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
  assign eligible = !settled[p_idx];
  assign upd      = eligible && (!reached[p_idx] || (nd < d_rd));
  assign nv       = upd ? nd : d_rd;
  assign better   = eligible && (!found || (nv < best_dist));

  assign d_we    = ((state == ST_INIT) && src_active)
                   || ((state == ST_RELAX) && p_vld && upd);
  assign d_waddr = (state == ST_INIT) ? cur_node : p_idx;
  assign d_wdata = (state == ST_INIT) ? '0 : nd;
  assign d_re    = ((state == ST_RELAX) && (idx < n_eff)) || (state == ST_FETCH);
  assign d_raddr = (state == ST_FETCH) ? NODE_W'(target) : idx[NODE_W-1:0];

  spdg_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_NODES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(d_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RESET;
      source_node <= SOURCE_NODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NODE_COUNT:  node_count  <= COUNT_W'(cfg_data);
        REG_SOURCE_NODE: source_node <= NODE_FIELD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      n_eff   <= '0;
      reached <= '0;
      settled <= '0;
      idx     <= '0;
      p_vld   <= 1'b0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (cmd.operation == OP_QUERY)) begin
            n_eff      <= n_calc;
            target     <= cmd.target_node;
            target_bad <= tgt_out;
            src_active <= src_ok;
            cur_node   <= NODE_W'(source_node);
            cur_dist   <= '0;
            reached    <= '0;
            settled    <= '0;
            state      <= ST_INIT;
          end
        end
        ST_INIT: begin
          if (src_active) begin
            reached[cur_node] <= 1'b1;
            settled[cur_node] <= 1'b1;
            idx               <= '0;
            p_vld             <= 1'b0;
            found             <= 1'b0;
            state             <= ST_RELAX;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_RELAX: begin
          p_vld <= (idx < n_eff);
          p_idx <= idx[NODE_W-1:0];
          if (idx < n_eff) begin
            idx <= idx + CNT_W'(1);
          end
          if (p_vld) begin
            if (upd) begin
              reached[p_idx] <= 1'b1;
            end
            if (better) begin
              found     <= 1'b1;
              best_node <= p_idx;
              best_dist <= nv;
            end
          end
          if ((idx == n_eff) && !p_vld) begin
            if (found) begin
              cur_node           <= best_node;
              cur_dist           <= best_dist;
              settled[best_node] <= 1'b1;
              idx                <= '0;
              found              <= 1'b0;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          result.target_invalid <= target_bad;
          result.distance       <= (target_bad || !src_active || !reached[NODE_W'(target)])
                                   ? '0 : d_rd;
          done                  <= 1'b1;
          state                 <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_dist_no_overlap, clk, rst, d_we && d_re, d_waddr != d_raddr, "distance memory read and write hit one entry")
  `ASSERT_NEXT(a_query_busy, clk, rst, accept && (cmd.operation == OP_QUERY), busy, "query transaction did not raise busy")
  `ASSERT_IMPLY(a_invalid_zero, clk, rst, done && result.target_invalid, result.distance == '0, "invalid target with nonzero distance")
  `ASSERT_ALWAYS(a_settled_bound, clk, rst, $countones(settled) <= 32'(n_eff), "more nodes settled than active")

endmodule

>>> hdl/spdg_ram.sv
module spdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spdg_pkg::*;

  localparam int NODES          = DEFAULT_MAX_NODES;
  localparam int FILL_NODES     = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_GROUPS     = 8;
  localparam int GROUP_ITEMS    = 7;
  localparam int NUM_DIRECTED   = 25;
  localparam int IDLE_PCT [4]   = '{0, 79, 0, 36};

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_SET_NODES,
    ROW_SET_SOURCE
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [COUNT_W-1:0]        val;
    logic [NODE_FIELD_W-1:0]   col;
    logic [WEIGHT_FIELD_W-1:0] weight;
    logic                      typed;
    result_t                   want;
  } stim_row_t;

  localparam result_t R_ZERO    = '{distance: '0, target_invalid: 1'b0};
  localparam result_t R_INVALID = '{distance: '0, target_invalid: 1'b1};

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{ROW_QUERY,      7'd0,   6'd0,  16'd0,      1'b1, R_ZERO},
    '{ROW_QUERY,      7'd63,  6'd0,  16'd0,      1'b1, R_INVALID},
    '{ROW_QUERY,      7'd1,   6'd0,  16'd0,      1'b1, R_INVALID},
    '{ROW_SET_NODES,  7'd0,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd0,   6'd0,  16'd0,      1'b1, R_INVALID},
    '{ROW_SET_NODES,  7'd3,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_SET_SOURCE, 7'd63,  6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd2,   6'd0,  16'd0,      1'b1, R_ZERO},
    '{ROW_QUERY,      7'd3,   6'd0,  16'd0,      1'b1, R_INVALID},
    '{ROW_SET_SOURCE, 7'd0,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_LOAD,       7'd0,   6'd1,  16'd10,     1'b0, R_ZERO},
    '{ROW_LOAD,       7'd0,   6'd2,  16'hFFFF,   1'b0, R_ZERO},
    '{ROW_LOAD,       7'd1,   6'd2,  16'd0,      1'b0, R_ZERO},
    '{ROW_LOAD,       7'd1,   6'd0,  16'hFFFF,   1'b0, R_ZERO},
    '{ROW_LOAD,       7'd2,   6'd0,  16'd1,      1'b0, R_ZERO},
    '{ROW_LOAD,       7'd2,   6'd1,  16'd7,      1'b0, R_ZERO},
    '{ROW_LOAD,       7'd1,   6'd1,  16'hFFFF,   1'b0, R_ZERO},
    '{ROW_QUERY,      7'd2,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd1,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd0,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_SET_SOURCE, 7'd66,  6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd0,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_QUERY,      7'd1,   6'd0,  16'd0,      1'b0, R_ZERO},
    '{ROW_LOAD,       7'd63,  6'd63, 16'h5A5A,   1'b0, R_ZERO},
    '{ROW_LOAD,       7'd63,  6'd0,  16'hFFFF,   1'b0, R_ZERO}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  cmd_t                   cmd = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [WEIGHT_FIELD_W-1:0] weight_mem [NODES*NODES];
  logic [COUNT_W-1:0]        node_count_cfg = NODE_COUNT_RESET;
  logic [NODE_FIELD_W-1:0]   source_cfg = SOURCE_NODE_RESET;
  result_t                   pending_results [$];
  result_t                   head;

  int mismatch_count = 0;
  int results_checked = 0;
  int load_count = 0;
  int query_count = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  shortest_path_dense_graph dut (
    .clk,
    .rst,
    .start,
    .busy,
    .cmd,
    .done,
    .result,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  always #6 clk = ~clk;

  function automatic result_t shortest_distance(logic [NODE_FIELD_W-1:0] target);
    logic [DIST_W-1:0] best [NODES];
    bit                closed [NODES];
    bit                seen [NODES];
    int                n;
    int                u;
    bit                found;
    int unsigned       cand;
    result_t           r;
    n = (node_count_cfg > NODES) ? NODES : int'(node_count_cfg);
    for (int i = 0; i < NODES; i++) begin
      best[i] = '0;
      closed[i] = 1'b0;
      seen[i] = 1'b0;
    end
    if (source_cfg < n) begin
      seen[source_cfg] = 1'b1;
      for (int round = 0; round < n; round++) begin
        found = 1'b0;
        u = 0;
        for (int i = 0; i < n; i++) begin
          if (seen[i] && !closed[i] && (!found || best[i] < best[u])) begin
            u = i;
            found = 1'b1;
          end
        end
        if (!found) break;
        closed[u] = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (i != u && !closed[i]) begin
            cand = best[u] + weight_mem[u*NODES + i];
            if (cand > DIST_MAX) cand = DIST_MAX;
            if (!seen[i] || cand < best[i]) begin
              best[i] = cand[DIST_W-1:0];
              seen[i] = 1'b1;
            end
          end
        end
      end
    end
    r.target_invalid = (target >= n);
    r.distance = r.target_invalid ? '0 : best[target];
    return r;
  endfunction

  function automatic logic [WEIGHT_FIELD_W-1:0] pick_weight();
    case ($urandom_range(3))
      0: return WEIGHT_FIELD_W'($urandom_range(15));
      1: return WEIGHT_FIELD_W'(16'hFFFF - $urandom_range(15));
      default: return WEIGHT_FIELD_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic issue_command(cmd_t c, int idle_pct, bit typed, result_t typed_want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    if (c.operation == OP_LOAD) begin
      weight_mem[{c.from_node, c.to_node}] = c.edge_weight;
      load_count++;
    end else begin
      pending_results.insert(pending_results.size(),
                             typed ? typed_want : shortest_distance(c.target_node));
      query_count++;
    end
  endtask

  task automatic drain_queries();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_NODE_COUNT) node_count_cfg = val;
    else source_cfg = val[NODE_FIELD_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        head = pending_results.pop_front();
        if (result.distance !== head.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    result.distance, head.distance));
        if (result.target_invalid !== head.target_invalid)
          report_mismatch($sformatf("target_invalid %0b, expected %0b",
                                    result.target_invalid, head.target_invalid));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t                    c;
    stim_row_t               row;
    logic [COUNT_W-1:0]      nodes_val;
    logic [CFG_DATA_W-1:0]   src_val;
    int                      n_eff;
    int                      idle_pct;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      c.from_node = NODE_FIELD_W'($urandom);
      c.to_node = NODE_FIELD_W'($urandom);
      c.edge_weight = WEIGHT_FIELD_W'($urandom);
      c.target_node = NODE_FIELD_W'($urandom);
      case (row.kind)
        ROW_LOAD: begin
          c.operation = OP_LOAD;
          c.from_node = row.val[NODE_FIELD_W-1:0];
          c.to_node = row.col;
          c.edge_weight = row.weight;
          issue_command(c, 0, 1'b0, R_ZERO);
        end
        ROW_QUERY: begin
          c.operation = OP_QUERY;
          c.target_node = row.val[NODE_FIELD_W-1:0];
          issue_command(c, 0, row.typed, row.want);
        end
        ROW_SET_NODES: begin
          drain_queries();
          write_register(REG_NODE_COUNT, row.val);
        end
        default: begin
          drain_queries();
          write_register(REG_SOURCE_NODE, row.val);
        end
      endcase
    end

    // fill the corner of the matrix that the random groups search
    for (int i = 0; i < FILL_NODES*FILL_NODES; i++) begin
      c.operation = OP_LOAD;
      c.from_node = NODE_FIELD_W'(i / FILL_NODES);
      c.to_node = NODE_FIELD_W'(i % FILL_NODES);
      c.edge_weight = pick_weight();
      c.target_node = NODE_FIELD_W'($urandom);
      issue_command(c, 0, 1'b0, R_ZERO);
    end

    for (int g = 0; g < NUM_GROUPS; g++) begin
      case (g % 4)
        0: nodes_val = COUNT_W'(FILL_NODES);
        default: nodes_val = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(1))
                                                       : COUNT_W'($urandom_range(2, FILL_NODES));
      endcase
      n_eff = (nodes_val > NODES) ? NODES : int'(nodes_val);
      if (g == 0) src_val = 7'd63;
      else if (n_eff == 0 || $urandom_range(7) == 0) src_val = CFG_DATA_W'($urandom_range(127));
      else src_val = CFG_DATA_W'($urandom_range(n_eff - 1));
      drain_queries();
      write_register(REG_NODE_COUNT, nodes_val);
      write_register(REG_SOURCE_NODE, src_val);
      idle_pct = IDLE_PCT[g % 4];

      for (int k = 0; k < GROUP_ITEMS; k++) begin
        c.from_node = NODE_FIELD_W'($urandom);
        c.to_node = NODE_FIELD_W'($urandom);
        c.edge_weight = WEIGHT_FIELD_W'($urandom);
        c.target_node = NODE_FIELD_W'($urandom);
        if ($urandom_range(1) == 0) begin
          c.operation = OP_LOAD;
          if (n_eff > 0 && $urandom_range(3) != 0) begin
            c.from_node = NODE_FIELD_W'($urandom_range(n_eff - 1));
            c.to_node = NODE_FIELD_W'($urandom_range(n_eff - 1));
          end
          c.edge_weight = pick_weight();
        end else begin
          c.operation = OP_QUERY;
          if (n_eff > 0 && $urandom_range(4) != 0)
            c.target_node = NODE_FIELD_W'($urandom_range(n_eff - 1));
        end
        issue_command(c, idle_pct, 1'b0, R_ZERO);
      end
    end

    drain_queries();
    repeat (8) @(posedge clk);

    $display("Covered %0d edge loads and %0d distance queries across %0d register writes,",
             load_count, query_count, reg_writes);
    $display("node counts from 0 to 8, sources inside and outside the active set.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
